>>> rtl/core/scancode_set1_key_event_decoder_top_assert.svh
// Assertion macros for the set-1 scancode decoder RTL.
// Used by the FIFO and the top level; expects clk and rst in scope.
`ifndef SCANCODE_SET1_KEY_EVENT_DECODER_TOP_ASSERT_SVH
`define SCANCODE_SET1_KEY_EVENT_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SCS1_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scs1 assertion failed");
// Next-cycle implication.
`define SCS1_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scs1 assertion failed");
`else
`define SCS1_ASSERT_NOW(label, ante, cons)
`define SCS1_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/scs1_pkg.sv
// Shared types, constants and keymap tables for the set-1 scancode decoder.
// No dependencies.
`default_nettype none
package scs1_pkg;

  localparam int DEF_FIFO_DEPTH = 64;

  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT  = 7'h36;
  localparam logic [6:0] KEY_CTRL    = 7'h1D;
  localparam logic [6:0] KEY_ALT     = 7'h38;
  localparam logic [6:0] KEY_CAPS    = 7'h3A;
  localparam logic [6:0] TABLE_LEN   = 7'd89;

  // Key event word as held in the FIFO.
  typedef struct packed {
    logic [6:0] ascii;
    logic [6:0] key_code;
    logic       is_extended;
    logic       alt;
    logic       ctrl;
    logic       shift;
    logic       pressed;
  } ev_t;

  typedef struct packed {
    logic push;
    ev_t  ev;
  } push_req_t;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
  } mods_t;

  // The ten extended navigation keys.
  function automatic logic is_nav(input logic [6:0] code);
    logic hit;
    hit = 1'b0;
    unique case (code)
      7'h47, 7'h48, 7'h49, 7'h4B, 7'h4D,
      7'h4F, 7'h50, 7'h51, 7'h52, 7'h53: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // US keymap; upper selects the shifted column. Unmapped codes give 0.
  function automatic logic [6:0] ascii_lookup(input logic [6:0] code, input logic upper);
    logic [6:0] a;
    a = 7'h00;
    unique case (code)
      7'd1:  a = 7'h1B;
      7'd2:  a = upper ? 7'h21 : 7'h31;
      7'd3:  a = upper ? 7'h40 : 7'h32;
      7'd4:  a = upper ? 7'h23 : 7'h33;
      7'd5:  a = upper ? 7'h24 : 7'h34;
      7'd6:  a = upper ? 7'h25 : 7'h35;
      7'd7:  a = upper ? 7'h5E : 7'h36;
      7'd8:  a = upper ? 7'h26 : 7'h37;
      7'd9:  a = upper ? 7'h2A : 7'h38;
      7'd10: a = upper ? 7'h28 : 7'h39;
      7'd11: a = upper ? 7'h29 : 7'h30;
      7'd12: a = upper ? 7'h5F : 7'h2D;
      7'd13: a = upper ? 7'h2B : 7'h3D;
      7'd14: a = 7'h08;
      7'd15: a = 7'h09;
      7'd16: a = upper ? 7'h51 : 7'h71;
      7'd17: a = upper ? 7'h57 : 7'h77;
      7'd18: a = upper ? 7'h45 : 7'h65;
      7'd19: a = upper ? 7'h52 : 7'h72;
      7'd20: a = upper ? 7'h54 : 7'h74;
      7'd21: a = upper ? 7'h59 : 7'h79;
      7'd22: a = upper ? 7'h55 : 7'h75;
      7'd23: a = upper ? 7'h49 : 7'h69;
      7'd24: a = upper ? 7'h4F : 7'h6F;
      7'd25: a = upper ? 7'h50 : 7'h70;
      7'd26: a = upper ? 7'h7B : 7'h5B;
      7'd27: a = upper ? 7'h7D : 7'h5D;
      7'd28: a = 7'h0A;
      7'd30: a = upper ? 7'h41 : 7'h61;
      7'd31: a = upper ? 7'h53 : 7'h73;
      7'd32: a = upper ? 7'h44 : 7'h64;
      7'd33: a = upper ? 7'h46 : 7'h66;
      7'd34: a = upper ? 7'h47 : 7'h67;
      7'd35: a = upper ? 7'h48 : 7'h68;
      7'd36: a = upper ? 7'h4A : 7'h6A;
      7'd37: a = upper ? 7'h4B : 7'h6B;
      7'd38: a = upper ? 7'h4C : 7'h6C;
      7'd39: a = upper ? 7'h3A : 7'h3B;
      7'd40: a = upper ? 7'h22 : 7'h27;
      7'd41: a = upper ? 7'h7E : 7'h60;
      7'd43: a = upper ? 7'h7C : 7'h5C;
      7'd44: a = upper ? 7'h5A : 7'h7A;
      7'd45: a = upper ? 7'h58 : 7'h78;
      7'd46: a = upper ? 7'h43 : 7'h63;
      7'd47: a = upper ? 7'h56 : 7'h76;
      7'd48: a = upper ? 7'h42 : 7'h62;
      7'd49: a = upper ? 7'h4E : 7'h6E;
      7'd50: a = upper ? 7'h4D : 7'h6D;
      7'd51: a = upper ? 7'h3C : 7'h2C;
      7'd52: a = upper ? 7'h3E : 7'h2E;
      7'd53: a = upper ? 7'h3F : 7'h2F;
      7'd55: a = 7'h2A;
      7'd57: a = 7'h20;
      7'd71: a = 7'h37;
      7'd72: a = 7'h38;
      7'd73: a = 7'h39;
      7'd74: a = 7'h2D;
      7'd75: a = 7'h34;
      7'd76: a = 7'h35;
      7'd77: a = 7'h36;
      7'd78: a = 7'h2B;
      7'd79: a = 7'h31;
      7'd80: a = 7'h32;
      7'd81: a = 7'h33;
      7'd82: a = 7'h30;
      7'd83: a = 7'h2E;
      default: a = 7'h00;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/scs1_decode.sv
// Scancode decoder: enable register, prefix and modifier flags, event builder.
// Depends on scs1_pkg.
`default_nettype none
module scs1_decode (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire                    cfg_data,
  input  wire                    byte_take,
  input  wire  [7:0]             scancode,
  output scs1_pkg::push_req_t    push_req,
  output scs1_pkg::mods_t        mods
);

  logic enable;
  logic prefix_seen, prefix_seen_next;
  logic shift_held, shift_held_next;
  logic ctrl_held, ctrl_held_next;
  logic alt_held, alt_held_next;
  logic caps_on, caps_on_next;

  logic       released;
  logic [6:0] code;

  assign released = scancode[7];
  assign code     = scancode[6:0];
  assign mods     = '{shift: shift_held, ctrl: ctrl_held, alt: alt_held};

  always_comb begin
    prefix_seen_next = prefix_seen;
    shift_held_next  = shift_held;
    ctrl_held_next   = ctrl_held;
    alt_held_next    = alt_held;
    caps_on_next     = caps_on;
    push_req.push             = 1'b0;
    push_req.ev.pressed       = ~released;
    push_req.ev.shift         = shift_held;
    push_req.ev.ctrl          = ctrl_held;
    push_req.ev.alt           = alt_held;
    push_req.ev.is_extended   = prefix_seen;
    push_req.ev.key_code      = code;
    push_req.ev.ascii         = prefix_seen ? 7'h00
                              : scs1_pkg::ascii_lookup(code, shift_held ^ caps_on);
    if (enable && byte_take) begin
      priority if (scancode == scs1_pkg::PREFIX_BYTE) begin
        prefix_seen_next = 1'b1;
      end else if (code == scs1_pkg::KEY_LSHIFT || code == scs1_pkg::KEY_RSHIFT) begin
        shift_held_next  = ~released;
        prefix_seen_next = 1'b0;
      end else if (code == scs1_pkg::KEY_CTRL) begin
        ctrl_held_next   = ~released;
        prefix_seen_next = 1'b0;
      end else if (code == scs1_pkg::KEY_ALT) begin
        alt_held_next    = ~released;
        prefix_seen_next = 1'b0;
      end else if (code == scs1_pkg::KEY_CAPS && !released) begin
        caps_on_next     = ~caps_on;
        prefix_seen_next = 1'b0;
      end else if (prefix_seen) begin
        // Extended: only navigation keys make events.
        prefix_seen_next = 1'b0;
        push_req.push    = scs1_pkg::is_nav(code);
      end else begin
        push_req.push = (code != 7'd0) && (code < scs1_pkg::TABLE_LEN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      prefix_seen <= 1'b0;
      shift_held  <= 1'b0;
      ctrl_held   <= 1'b0;
      alt_held    <= 1'b0;
      caps_on     <= 1'b0;
    end else begin
      if (cfg_we) begin
        enable <= cfg_data;
      end
      prefix_seen <= prefix_seen_next;
      shift_held  <= shift_held_next;
      ctrl_held   <= ctrl_held_next;
      alt_held    <= alt_held_next;
      caps_on     <= caps_on_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/scs1_fifo.sv
// Key event ring FIFO holding DEPTH-1 words, registered read port.
// Depends on scs1_pkg and the assertion macro header.
`default_nettype none
`include "scancode_set1_key_event_decoder_top_assert.svh"
module scs1_fifo #(
  parameter int DEPTH = scs1_pkg::DEF_FIFO_DEPTH
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire scs1_pkg::push_req_t  push_req,
  input  wire                       pop_req,
  output scs1_pkg::ev_t             rd_data,
  output logic                      rd_hit
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  scs1_pkg::ev_t mem [DEPTH];

  logic [PTR_W-1:0] write_ptr, read_ptr;
  logic [PTR_W-1:0] write_ptr_next, read_ptr_next;
  logic             empty, full, do_push, do_pop;

  assign write_ptr_next = (write_ptr == LAST) ? '0 : write_ptr + 1'b1;
  assign read_ptr_next  = (read_ptr == LAST) ? '0 : read_ptr + 1'b1;
  assign empty   = (write_ptr == read_ptr);
  assign full    = (write_ptr_next == read_ptr);
  // Drop a push into a full FIFO.
  assign do_push = push_req.push && !full;
  assign do_pop  = pop_req && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
    end else begin
      if (do_push) begin
        write_ptr <= write_ptr_next;
      end
      if (do_pop) begin
        read_ptr <= read_ptr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[write_ptr] <= push_req.ev;
    end
  end

  // Hold the read word until the next pop request.
  always_ff @(posedge clk) begin
    if (pop_req) begin
      rd_data <= mem[read_ptr];
      rd_hit  <= !empty;
    end
  end

  `SCS1_ASSERT_NOW(a_no_push_and_pop, push_req.push, !pop_req)
  `SCS1_ASSERT_NEXT(a_full_drops, push_req.push && full, write_ptr == $past(write_ptr))
  `SCS1_ASSERT_NEXT(a_pop_advances, do_pop, read_ptr == $past(read_ptr_next))

endmodule
`default_nettype wire

>>> rtl/core/scancode_set1_key_event_decoder_top.sv
// Top level of the set-1 scancode decoder with key event FIFO.
// Depends on scs1_pkg, scs1_decode, scs1_fifo and the assertion macro header.
//
// Input channel (in_valid/in_ready) moves one word: cmd and scancode.
//   cmd 0: a set-1 scancode byte; it updates prefix/modifier/caps state and
//          may queue one key event. It produces no output word.
//   cmd 1: read request; it pops the oldest event (or reports empty) and
//          produces exactly one output word, with the current modifiers.
// Output channel (out_valid/out_ready) carries the read result fields.
// Config: cfg_we/cfg_data write the enable bit at once; while it is zero,
//   scancode bytes are dropped, reads still work.
// Pipeline: the accepted word sits in the input register, where it is
//   decoded and the FIFO is written or read; the FIFO read port and the
//   output register then deliver the result with out_valid. Throughput is
//   one word per cycle while no read waits on a stalled output register,
//   set by the input register, which holds a single word.
// Stall: with out_ready low the output word holds; one more word is still
//   taken, and scancode words keep flowing; a read word waits in the input
//   register until the output register frees.
// Reset clears flags, pointers and valids; FIFO contents need no clearing.
`default_nettype none
`include "scancode_set1_key_event_decoder_top_assert.svh"
module scancode_set1_key_event_decoder_top #(
  parameter int FIFO_DEPTH = scs1_pkg::DEF_FIFO_DEPTH
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire        cfg_data,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        cmd,
  input  wire  [7:0] scancode,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       valid_res,
  output logic       pressed,
  output logic       shift_at_event,
  output logic       ctrl_at_event,
  output logic       alt_at_event,
  output logic       is_extended,
  output logic [6:0] key_code,
  output logic [6:0] ascii,
  output logic       shift_now,
  output logic       ctrl_now,
  output logic       alt_now
);

  // Input register.
  logic       s1_valid;
  logic       s1_cmd;
  logic [7:0] s1_scancode;
  // Output register (event word comes from the FIFO read register).
  logic       s2_valid;
  scs1_pkg::mods_t s2_mods;

  logic s2_free, byte_take, pop_req, s1_done;

  scs1_pkg::push_req_t push_req;
  scs1_pkg::mods_t     mods;
  scs1_pkg::ev_t       rd_data;
  logic                rd_hit;

  assign s2_free   = !s2_valid || out_ready;
  assign byte_take = s1_valid && (s1_cmd == scs1_pkg::CMD_SCAN);
  assign pop_req   = s1_valid && (s1_cmd == scs1_pkg::CMD_READ) && s2_free;
  assign s1_done   = byte_take || pop_req;
  assign in_ready  = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (pop_req) begin
        s2_valid <= 1'b1;
      end else if (out_ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd      <= cmd;
      s1_scancode <= scancode;
    end
    // Capture modifiers as they stand when the read is served.
    if (pop_req) begin
      s2_mods <= mods;
    end
  end

  scs1_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .byte_take (byte_take),
    .scancode  (s1_scancode),
    .push_req  (push_req),
    .mods      (mods)
  );

  scs1_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_req (push_req),
    .pop_req  (pop_req),
    .rd_data  (rd_data),
    .rd_hit   (rd_hit)
  );

  // Zero the event fields on an empty read.
  assign out_valid      = s2_valid;
  assign valid_res      = rd_hit;
  assign pressed        = rd_hit & rd_data.pressed;
  assign shift_at_event = rd_hit & rd_data.shift;
  assign ctrl_at_event  = rd_hit & rd_data.ctrl;
  assign alt_at_event   = rd_hit & rd_data.alt;
  assign is_extended    = rd_hit & rd_data.is_extended;
  assign key_code       = rd_hit ? rd_data.key_code : 7'h00;
  assign ascii          = rd_hit ? rd_data.ascii : 7'h00;
  assign shift_now      = s2_mods.shift;
  assign ctrl_now       = s2_mods.ctrl;
  assign alt_now        = s2_mods.alt;

  `SCS1_ASSERT_NOW(a_stall_only_on_read,
    !in_ready, s1_valid && s1_cmd == scs1_pkg::CMD_READ && s2_valid && !out_ready)
  `SCS1_ASSERT_NOW(a_empty_read_zero,
    out_valid && !valid_res, key_code == 7'h00 && ascii == 7'h00 && !pressed)
  `SCS1_ASSERT_NEXT(a_pop_gives_result, pop_req, out_valid)

endmodule
`default_nettype wire

>>> tb/sv/tb_scancode_set1_key_event_decoder_top.sv
// Testbench for scancode_set1_key_event_decoder_top: drives scancode and read words,
// predicts every read reply in-line and checks it field by field on the output channel.
// Depends on scs1_pkg and the decoder RTL only.
module tb_scancode_set1_key_event_decoder_top;

  localparam int          EVENT_SLOTS    = scs1_pkg::DEF_FIFO_DEPTH - 1;  // one slot free
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [7:0]  REL_BIT        = 8'h80;
  localparam logic [6:0]  KEY_ESC        = 7'h01;
  localparam logic [6:0]  KEY_Q          = 7'h10;
  localparam logic [6:0]  KEY_A          = 7'h1E;
  localparam logic [6:0]  KEY_LAST       = 7'h58;  // highest code with a table entry
  localparam logic [6:0]  NAV_UP         = 7'h48;

  // One read reply as it leaves the block.
  typedef struct packed {
    logic          valid;
    scs1_pkg::ev_t ev;
    logic          shift_now;
    logic          ctrl_now;
    logic          alt_now;
  } read_reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       cmd = scs1_pkg::CMD_SCAN;
  logic [7:0] scancode = 8'h00;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire        valid_res;
  wire        pressed;
  wire        shift_at_event;
  wire        ctrl_at_event;
  wire        alt_at_event;
  wire        is_extended;
  wire  [6:0] key_code;
  wire  [6:0] ascii;
  wire        shift_now;
  wire        ctrl_now;
  wire        alt_now;

  // US key map, unshifted and shifted columns, indexed by key code 0..88.
  logic [6:0] plain_chars [0:88] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };
  logic [6:0] upper_chars [0:88] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };
  // Extended navigation keys: home, up, pgup, left, right, end, down, pgdn, ins, del.
  logic [6:0] nav_keys [10] = '{
    7'h47, 7'h48, 7'h49, 7'h4B, 7'h4D, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53
  };
  logic [6:0] modifier_keys [4] = '{
    scs1_pkg::KEY_LSHIFT, scs1_pkg::KEY_RSHIFT, scs1_pkg::KEY_CTRL, scs1_pkg::KEY_ALT
  };

  // Shadow of the decoder state, advanced as each word is accepted.
  logic          enable_q = 1'b0;
  logic          prefix_armed = 1'b0;
  logic          shift_dn = 1'b0;
  logic          ctrl_dn = 1'b0;
  logic          alt_dn = 1'b0;
  logic          caps_lock = 1'b0;
  scs1_pkg::ev_t key_events [$];    // events queued inside the block
  read_reply_t   replies_due [$];   // read replies not yet seen on the output

  int          idle_pct = 0;      // chance per cycle that the sender idles
  int          stall_pct = 0;     // chance per cycle that the receiver stalls
  int          hold_left = 0;     // cycles of forced receiver hold-off still to go
  int          words_sent = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  scancode_set1_key_event_decoder_top u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .scancode       (scancode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .valid_res      (valid_res),
    .pressed        (pressed),
    .shift_at_event (shift_at_event),
    .ctrl_at_event  (ctrl_at_event),
    .alt_at_event   (alt_at_event),
    .is_extended    (is_extended),
    .key_code       (key_code),
    .ascii          (ascii),
    .shift_now      (shift_now),
    .ctrl_now       (ctrl_now),
    .alt_now        (alt_now)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  function automatic bit nav_key(input logic [6:0] code);
    foreach (nav_keys[i]) begin
      if (nav_keys[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Queue one key event stamped with the modifiers held right now; drop it when full.
  function automatic void queue_key_event(input logic make, input logic ext,
                                          input logic [6:0] code, input logic [6:0] ch);
    scs1_pkg::ev_t e;
    if (key_events.size() >= EVENT_SLOTS) return;
    e.pressed     = make;
    e.shift       = shift_dn;
    e.ctrl        = ctrl_dn;
    e.alt         = alt_dn;
    e.is_extended = ext;
    e.key_code    = code;
    e.ascii       = ch;
    key_events.push_back(e);
  endfunction

  // Advance the shadow state for one scancode byte.
  function automatic void decode_scan_byte(input logic [7:0] sc);
    logic       make;
    logic [6:0] code;
    make = ~sc[7];
    code = sc[6:0];
    if (!enable_q) return;
    if (sc == scs1_pkg::PREFIX_BYTE) begin
      prefix_armed = 1'b1;
      return;
    end
    // Modifier bytes and a caps make consume any pending prefix.
    if (code == scs1_pkg::KEY_LSHIFT || code == scs1_pkg::KEY_RSHIFT) begin
      shift_dn = make;
      prefix_armed = 1'b0;
    end else if (code == scs1_pkg::KEY_CTRL) begin
      ctrl_dn = make;
      prefix_armed = 1'b0;
    end else if (code == scs1_pkg::KEY_ALT) begin
      alt_dn = make;
      prefix_armed = 1'b0;
    end else if (code == scs1_pkg::KEY_CAPS && make) begin
      caps_lock = ~caps_lock;
      prefix_armed = 1'b0;
    end else if (prefix_armed) begin
      // Extended byte: only navigation keys survive, with no character.
      prefix_armed = 1'b0;
      if (nav_key(code)) queue_key_event(make, 1'b1, code, 7'h00);
    end else if (code >= 7'd1 && code < scs1_pkg::TABLE_LEN) begin
      queue_key_event(make, 1'b0, code,
                      (shift_dn ^ caps_lock) ? upper_chars[code] : plain_chars[code]);
    end
  endfunction

  // Pop the oldest event (or report empty) and stamp the current modifiers.
  function automatic void predict_read_reply();
    read_reply_t r;
    r = '0;
    if (key_events.size() != 0) begin
      r.valid = 1'b1;
      r.ev    = key_events.pop_front();
    end
    r.shift_now = shift_dn;
    r.ctrl_now  = ctrl_dn;
    r.alt_now   = alt_dn;
    replies_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one word; idle first at random, then hold valid until the block takes it.
  task automatic send_word(input logic c, input logic [7:0] sc);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    scancode <= sc;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (c == scs1_pkg::CMD_READ) predict_read_reply();
    else decode_scan_byte(sc);
  endtask

  task automatic send_scan(input logic [7:0] sc);
    send_word(scs1_pkg::CMD_SCAN, sc);
  endtask

  task automatic send_read();
    send_word(scs1_pkg::CMD_READ, 8'($urandom_range(255)));
  endtask

  // Drop valid and hold off until every reply has come and the pipeline is empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the enable register; only call while the block is drained.
  task automatic write_enable(input logic v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    enable_q = v;
  endtask

  // One burst of keyboard traffic: mostly real keystroke sequences, some noise,
  // followed by up to three reads.
  task automatic send_random_group();
    int unsigned pick;
    logic [6:0]  key;
    logic [6:0]  mod;
    bit          with_mod;
    pick     = $urandom_range(99);
    key      = 7'($urandom_range(1, 88));
    mod      = modifier_keys[$urandom_range(3)];
    with_mod = ($urandom_range(2) == 0);
    if (pick < 50) begin
      // Typed key, sometimes inside a modifier press.
      if (with_mod) send_scan({1'b0, mod});
      send_scan({1'b0, key});
      if ($urandom_range(1) != 0) send_read();
      send_scan(REL_BIT | {1'b0, key});
      if (with_mod) send_scan(REL_BIT | {1'b0, mod});
    end else if (pick < 68) begin
      // Navigation key make and break, each behind its prefix.
      key = nav_keys[$urandom_range(9)];
      send_scan(scs1_pkg::PREFIX_BYTE);
      send_scan({1'b0, key});
      send_scan(scs1_pkg::PREFIX_BYTE);
      send_scan(REL_BIT | {1'b0, key});
    end else if (pick < 74) begin
      send_scan({1'b0, scs1_pkg::KEY_CAPS});
      send_scan(REL_BIT | {1'b0, scs1_pkg::KEY_CAPS});
    end else if (pick < 88) begin
      send_scan(8'($urandom_range(255)));
    end else begin
      // Broken extended sequence: prefix followed by anything.
      send_scan(scs1_pkg::PREFIX_BYTE);
      send_scan(8'($urandom_range(255)));
    end
    repeat ($urandom_range(3)) send_read();
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Stall at random; a pending hold-off overrides the random choice.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [6:0] want,
                                      input logic [6:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each reply word with the oldest prediction.
  always @(posedge clk) begin
    read_reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply word, expected none, actual valid_res %0h code %0h",
                 $time, valid_res, key_code);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        check_field("valid_res", 7'(want.valid), 7'(valid_res));
        check_field("pressed", 7'(want.ev.pressed), 7'(pressed));
        check_field("shift_at_event", 7'(want.ev.shift), 7'(shift_at_event));
        check_field("ctrl_at_event", 7'(want.ev.ctrl), 7'(ctrl_at_event));
        check_field("alt_at_event", 7'(want.ev.alt), 7'(alt_at_event));
        check_field("is_extended", 7'(want.ev.is_extended), 7'(is_extended));
        check_field("key_code", want.ev.key_code, key_code);
        check_field("ascii", want.ev.ascii, ascii);
        check_field("shift_now", 7'(want.shift_now), 7'(shift_now));
        check_field("ctrl_now", 7'(want.ctrl_now), 7'(ctrl_now));
        check_field("alt_now", 7'(want.alt_now), 7'(alt_now));
      end
    end
  end

  // End the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[scancode_set1_key_event_decoder_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the decoder is disabled: bytes must change nothing, reads still answer.
  task automatic test_disabled_input();
    idle_pct  = 0;
    stall_pct = 0;
    send_scan({1'b0, scs1_pkg::KEY_LSHIFT});
    send_scan({1'b0, KEY_A});
    send_scan(scs1_pkg::PREFIX_BYTE);
    send_scan({1'b0, NAV_UP});
    send_read();
    wait_drained();
    write_enable(1'b1);
  endtask

  // Walk the modifier, caps and prefix corner cases by hand.
  task automatic test_directed_keys();
    send_read();                                          // empty FIFO
    send_scan({1'b0, KEY_A});                             // plain 'a'
    send_scan({1'b0, scs1_pkg::KEY_LSHIFT});
    send_scan({1'b0, KEY_Q});                             // shifted 'Q'
    send_scan(REL_BIT | {1'b0, scs1_pkg::KEY_LSHIFT});
    send_scan({1'b0, scs1_pkg::KEY_CAPS});                // caps on
    send_scan({1'b0, KEY_A});                             // caps gives 'A'
    send_scan({1'b0, scs1_pkg::KEY_RSHIFT});
    send_scan({1'b0, KEY_A});                             // shift cancels caps
    send_scan(REL_BIT | {1'b0, scs1_pkg::KEY_RSHIFT});
    send_scan(REL_BIT | {1'b0, scs1_pkg::KEY_CAPS});      // caps break is a plain event
    send_scan({1'b0, scs1_pkg::KEY_CTRL});
    send_scan({1'b0, scs1_pkg::KEY_ALT});
    send_scan({1'b0, KEY_ESC});                           // lowest table code
    send_scan(REL_BIT | {1'b0, KEY_LAST});                // highest table code, break
    send_scan(scs1_pkg::PREFIX_BYTE);
    send_scan(scs1_pkg::PREFIX_BYTE);                     // repeated prefix stays armed
    send_scan(REL_BIT | {1'b0, NAV_UP});                  // extended navigation break
    send_scan(scs1_pkg::PREFIX_BYTE);
    send_scan(REL_BIT | {1'b0, scs1_pkg::KEY_CTRL});      // modifier behind prefix
    send_scan(scs1_pkg::PREFIX_BYTE);
    send_scan(REL_BIT | {1'b0, scs1_pkg::KEY_CAPS});      // caps break behind prefix: dropped
    send_scan(scs1_pkg::PREFIX_BYTE);
    send_scan({1'b0, KEY_A});                             // non-navigation extended: dropped
    send_scan(8'hFF);                                     // code beyond the table
    send_scan(REL_BIT);                                   // code zero
    send_scan(REL_BIT | {1'b0, scs1_pkg::KEY_ALT});
    send_scan({1'b0, scs1_pkg::KEY_CAPS});                // caps off again
    repeat (9) send_read();                               // drain, last one empty
    wait_drained();
  endtask

  // Overfill the event ring so the extra events drop, then read one past empty.
  task automatic test_fifo_overflow();
    for (int i = 0; i < EVENT_SLOTS + 3; i++) begin
      send_scan({1'b0, 7'(KEY_Q + i % 10)});
    end
    repeat (EVENT_SLOTS + 1) send_read();
    wait_drained();
  endtask

  task automatic test_random_typing(input int idle, input int stall, input int count);
    int target;
    target    = words_sent + count;
    idle_pct  = idle;
    stall_pct = stall;
    while (words_sent < target) send_random_group();
    wait_drained();
  endtask

  // Disable mid-run: queued events still read out while new bytes are ignored.
  task automatic test_enable_toggle();
    idle_pct  = 12;
    stall_pct = 12;
    repeat (6) begin
      send_scan({1'b0, 7'($urandom_range(1, 88))});
    end
    wait_drained();
    write_enable(1'b0);
    repeat (8) send_random_group();
    wait_drained();
    write_enable(1'b1);
  endtask

  // Hold the receiver off for a long stretch while reads keep coming, so the
  // output and input registers fill and in_ready drops.
  task automatic test_output_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 200;
    repeat (12) begin
      send_scan({1'b0, 7'($urandom_range(1, 88))});
      send_read();
      send_read();
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_disabled_input();
    test_directed_keys();
    test_fifo_overflow();
    test_random_typing(0, 0, 150);
    test_random_typing(61, 0, 150);
    test_random_typing(0, 61, 150);
    test_random_typing(12, 12, 150);
    test_enable_toggle();
    test_output_backpressure();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[scancode_set1_key_event_decoder_top] OK");
    end else begin
      $display("[scancode_set1_key_event_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
